### rtl/ctb_pkg.sv
// Shared types, widths and codes for the cascaded timer block.
// No dependencies; every other rtl file imports this package.
`default_nettype none

package ctb_pkg;

    localparam int NUM_TIMERS_DEF = 4;
    localparam int CYCLE_BITS     = 8;
    localparam int CNT_W          = 16;
    localparam int ACC_W          = 11;
    localparam int MASK_W         = 4;
    // accumulator plus elapsed cycles, one bit of headroom
    localparam int TOT_W          = ((CYCLE_BITS > ACC_W) ? CYCLE_BITS : ACC_W) + 1;

    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_WR_RELOAD = 3'd1;
    localparam logic [2:0] OP_WR_CTRL   = 3'd2;
    localparam logic [2:0] OP_RD_COUNT  = 3'd3;
    localparam logic [2:0] OP_RD_CTRL   = 3'd4;

    localparam int CTRL_CASCADE_BIT = 2;
    localparam int CTRL_IRQ_BIT     = 6;
    localparam int CTRL_ENABLE_BIT  = 7;

    typedef struct packed {
        logic [2:0]            operation;
        logic [1:0]            timer_index;
        logic [CNT_W-1:0]      write_value;
        logic [CYCLE_BITS-1:0] cycles;
    } in_word_t;

    typedef struct packed {
        logic [CNT_W-1:0]  read_value;
        logic [MASK_W-1:0] overflow_mask;
        logic [MASK_W-1:0] irq_mask;
    } out_word_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic tload;
        logic step;
        logic store;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic in_tick;
        logic step_done;
        logic last_timer;
    } stat_t;

    // prescale periods 1, 64, 256, 1024 as shift amounts
    function automatic logic [3:0] prescale_shift(input logic [1:0] sel);
        logic [3:0] sh;
        case (sel)
            2'd0:    sh = 4'd0;
            2'd1:    sh = 4'd6;
            2'd2:    sh = 4'd8;
            default: sh = 4'd10;
        endcase
        return sh;
    endfunction

endpackage

`default_nettype wire

### rtl/cascaded_timer_block.sv
// Top level of the cascaded timer block: sequencer plus datapath.
// Depends on ctb_pkg, ctb_ctrl and ctb_dp.
//
//   channel | signals                        | word type
//   --------+--------------------------------+-----------
//   cmd     | cmd_valid, cmd_stall, cmd_word | in_word_t
//   rsp     | rsp_valid, rsp_stall, rsp_word | out_word_t
//
// A register access passes through EXEC and FIN from acceptance to result.
// A tick walks each timer through TLOAD, TSTEP (repeated for n increments,
// n = (accum + cycles) >> prescale shift, or 0/1 when cascaded) and
// TSTORE, then FIN; the single shared increment loop in the datapath counts n down.
// Reset clears all timer registers at once; no clearing pass.
// cmd is taken only while the sequencer is idle; a stalled result is held
// in the rsp register while the next word is already accepted.
`default_nettype none

module cascaded_timer_block
    import ctb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cmd_valid,
    output logic          cmd_stall,
    input  wire in_word_t cmd_word,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output out_word_t     rsp_word
);

    cmd_t  cmd;
    stat_t stat;

    ctb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd_valid),
        .in_stall  (cmd_stall),
        .out_valid (rsp_valid),
        .out_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    ctb_dp #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (cmd_word),
        .cmd      (cmd),
        .stat     (stat),
        .out_word (rsp_word)
    );

endmodule

`default_nettype wire

### rtl/ctb_ctrl.sv
// Sequencer for the cascaded timer block: handshakes and per-timer walk.
// Depends on ctb_pkg; drives commands into ctb_dp.
`default_nettype none

module ctb_ctrl
    import ctb_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  wire logic  out_stall,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_TLOAD  = 3'd2;
    localparam logic [2:0] S_TSTEP  = 3'd3;
    localparam logic [2:0] S_TSTORE = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.in_tick ? S_TLOAD : S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_FIN;
            end
            S_TLOAD:
            begin
                cmd.tload  = 1'b1;
                state_next = S_TSTEP;
            end
            S_TSTEP:
            begin
                if (stat.step_done)
                    state_next = S_TSTORE;
                else
                    cmd.step = 1'b1;
            end
            S_TSTORE:
            begin
                cmd.store  = 1'b1;
                state_next = stat.last_timer ? S_FIN : S_TLOAD;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### rtl/ctb_dp.sv
// Datapath of the cascaded timer block: timer registers, step counter,
// result register. Depends on ctb_pkg; commanded by ctb_ctrl.
`default_nettype none

module ctb_dp
    import ctb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire in_word_t in_word,
    input  wire cmd_t     cmd,
    output stat_t         stat,
    output out_word_t     out_word
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    logic [CNT_W-1:0] count_reg   [NUM_TIMERS];
    logic [CNT_W-1:0] reload_reg  [NUM_TIMERS];
    logic [CNT_W-1:0] control_reg [NUM_TIMERS];
    logic [ACC_W-1:0] accum_reg   [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] ovf_reg;
    logic [NUM_TIMERS-1:0] irq_reg;
    logic             prev_wrap_reg;
    logic [IDX_W-1:0] sel_reg, sel_next;

    in_word_t         item_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [TOT_W-1:0] left_reg;
    logic             wrap_reg;
    out_word_t        out_reg, out_next;

    logic [IDX_W+1:0] idx_ext;
    logic             idx_ok;
    logic [CNT_W-1:0] ctl;
    logic [3:0]       sh;
    logic [TOT_W-1:0] total;
    logic [TOT_W-1:0] periods;
    logic [TOT_W-1:0] rem_full;
    logic             casc_step;
    logic [NUM_TIMERS+MASK_W-1:0] ovf_pad;
    logic [NUM_TIMERS+MASK_W-1:0] irq_pad;

    assign idx_ext  = {{IDX_W{1'b0}}, in_word.timer_index};
    assign sel_next = (in_word.operation == OP_TICK) ? '0 : idx_ext[IDX_W-1:0];
    assign idx_ok   = 32'(item_reg.timer_index) < NUM_TIMERS;

    assign ctl       = control_reg[sel_reg];
    assign sh        = prescale_shift(ctl[1:0]);
    assign total     = TOT_W'(accum_reg[sel_reg]) + TOT_W'(item_reg.cycles);
    assign periods   = total >> sh;
    assign rem_full  = total & ((TOT_W'(1) << sh) - TOT_W'(1));
    // timer 0 has no lower neighbor, so cascade never fires there
    assign casc_step = (sel_reg != '0) && prev_wrap_reg;

    assign stat.in_tick    = (in_word.operation == OP_TICK);
    assign stat.step_done  = (left_reg == '0);
    assign stat.last_timer = (sel_reg == LAST_IDX);

    assign ovf_pad = {{MASK_W{1'b0}}, ovf_reg};
    assign irq_pad = {{MASK_W{1'b0}}, irq_reg};

    always_comb
    begin
        out_next = '0;
        case (item_reg.operation)
            OP_TICK:
            begin
                out_next.overflow_mask = ovf_pad[MASK_W-1:0];
                out_next.irq_mask      = irq_pad[MASK_W-1:0];
            end
            OP_RD_COUNT:
            begin
                if (idx_ok)
                    out_next.read_value = count_reg[sel_reg];
            end
            OP_RD_CTRL:
            begin
                if (idx_ok)
                    out_next.read_value = ctl;
            end
            default:
            begin
                out_next = '0;
            end
        endcase
    end

    // timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                count_reg[i]   <= '0;
                reload_reg[i]  <= '0;
                control_reg[i] <= '0;
                accum_reg[i]   <= '0;
            end
            ovf_reg       <= '0;
            irq_reg       <= '0;
            prev_wrap_reg <= 1'b0;
            sel_reg       <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                sel_reg <= sel_next;
                if (in_word.operation == OP_TICK)
                begin
                    ovf_reg       <= '0;
                    irq_reg       <= '0;
                    prev_wrap_reg <= 1'b0;
                end
            end
            if (cmd.exec && idx_ok)
            begin
                case (item_reg.operation)
                    OP_WR_RELOAD:
                    begin
                        reload_reg[sel_reg] <= item_reg.write_value;
                    end
                    OP_WR_CTRL:
                    begin
                        control_reg[sel_reg] <= item_reg.write_value;
                        // off-to-on edge restarts the timer from reload
                        if (!ctl[CTRL_ENABLE_BIT] && item_reg.write_value[CTRL_ENABLE_BIT])
                        begin
                            count_reg[sel_reg] <= reload_reg[sel_reg];
                            accum_reg[sel_reg] <= '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.tload && ctl[CTRL_ENABLE_BIT] && !ctl[CTRL_CASCADE_BIT])
                accum_reg[sel_reg] <= rem_full[ACC_W-1:0];
            if (cmd.store)
            begin
                count_reg[sel_reg] <= cnt_reg;
                ovf_reg[sel_reg]   <= wrap_reg;
                irq_reg[sel_reg]   <= wrap_reg && ctl[CTRL_IRQ_BIT];
                prev_wrap_reg      <= wrap_reg;
                if (sel_reg != LAST_IDX)
                    sel_reg <= sel_reg + IDX_W'(1);
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            item_reg <= in_word;
        if (cmd.tload)
        begin
            cnt_reg  <= count_reg[sel_reg];
            wrap_reg <= 1'b0;
            if (!ctl[CTRL_ENABLE_BIT])
                left_reg <= '0;
            else if (ctl[CTRL_CASCADE_BIT])
                left_reg <= TOT_W'(casc_step);
            else
                left_reg <= periods;
        end
        if (cmd.step)
        begin
            left_reg <= left_reg - TOT_W'(1);
            if (cnt_reg == {CNT_W{1'b1}})
            begin
                cnt_reg  <= reload_reg[sel_reg];
                wrap_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
        if (cmd.out_load)
            out_reg <= out_next;
    end

    assign out_word = out_reg;

`ifndef SYNTHESIS
    a_step_dec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> left_reg == $past(left_reg) - TOT_W'(1))
        else $error("step counter did not decrement");

    a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tload |-> 32'(sel_reg) < NUM_TIMERS)
        else $error("timer select out of range during tick");

    a_nontick_masks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && item_reg.operation != OP_TICK) |=>
            (out_reg.overflow_mask == '0 && out_reg.irq_mask == '0))
        else $error("masks set on a register access");

    a_irq_subset: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (out_reg.irq_mask & ~out_reg.overflow_mask) == '0)
        else $error("interrupt without overflow");
`endif

endmodule

`default_nettype wire
